[src/pnhs_pkg.sv]
// shared constants, codes and controller/datapath types for the next-hop selector
package pnhs_pkg;

  localparam int NODES       = 16;
  localparam int NODE_BITS   = $clog2(NODES);
  localparam int WEIGHT_BITS = 32;
  localparam int RAND_BITS   = 16;
  localparam int SUM_BITS    = WEIGHT_BITS + NODE_BITS;
  localparam int PROD_BITS   = SUM_BITS + RAND_BITS;
  localparam int ADDR_BITS   = 3 * NODE_BITS;
  localparam int DEPTH       = NODES * NODES * NODES;
  localparam int SCAN_BITS   = NODE_BITS + 1;
  localparam int HOP_BITS    = NODE_BITS + 1;
  localparam int LEN_BITS    = 10;

  localparam logic [LEN_BITS-1:0] LOOP_LENGTH = 10'd999;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_PATH  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SCAN_SUM  = 2'd0,
    SCAN_SEL  = 2'd1,
    SCAN_BEST = 2'd2
  } scan_t;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'd0,
    ST_IDLE   = 4'd1,
    ST_SUM    = 4'd2,
    ST_SCALE  = 4'd3,
    ST_CHECK  = 4'd4,
    ST_SELECT = 4'd5,
    ST_PCHECK = 4'd6,
    ST_PSCAN  = 4'd7,
    ST_PADV   = 4'd8,
    ST_DONE   = 4'd9
  } state_t;

  typedef struct packed {
    logic                 capture;
    logic                 clear_we;
    logic [ADDR_BITS-1:0] clear_addr;
    logic                 scan_rd;
    scan_t                scan_kind;
    logic [NODE_BITS-1:0] scan_idx;
    logic                 scale;
    logic                 best_init;
    logic                 mark;
    logic                 set_loop;
    logic                 advance;
    logic                 out_load;
  } dp_ctrl_t;

  typedef struct packed {
    logic r_zero;
    logic at_target;
    logic seen;
  } dp_stat_t;

endpackage

[src/pnhs_ram.sv]
// generic single-write, single-read ram with registered read data
module pnhs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/pnhs_dp.sv]
// datapath: weight table, row sum, scaling, roulette select, greedy path walk
module pnhs_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pnhs_pkg::dp_ctrl_t                    ctl,
  output pnhs_pkg::dp_stat_t                    stat,
  input  logic [1:0]                            command,
  input  logic [3:0]                            node,
  input  logic [3:0]                            target,
  input  logic [3:0]                            neighbour,
  input  logic [31:0]                           weight,
  input  logic [15:0]                           random_fraction,
  output logic [3:0]                            chosen_hop,
  output logic                                  no_hop,
  output logic [9:0]                            path_length,
  output logic                                  looped
);

  localparam int NB = pnhs_pkg::NODE_BITS;
  localparam int WB = pnhs_pkg::WEIGHT_BITS;
  localparam int SB = pnhs_pkg::SUM_BITS;
  localparam int PB = pnhs_pkg::PROD_BITS;
  localparam int RB = pnhs_pkg::RAND_BITS;
  localparam int AB = pnhs_pkg::ADDR_BITS;

  pnhs_pkg::cmd_t               cmd_q;
  logic [NB-1:0]                cur;
  logic [NB-1:0]                target_q;
  logic [RB-1:0]                frac_q;
  logic [pnhs_pkg::HOP_BITS-1:0] count;
  logic [pnhs_pkg::NODES-1:0]   visited;
  logic [SB-1:0]                sum;
  logic [SB-1:0]                acc;
  logic [SB-1:0]                acc_new;
  logic                         found;
  logic [NB-1:0]                hop;
  logic [PB-1:0]                prod;
  logic [SB-1:0]                r_val;
  logic [NB-1:0]                best;
  logic [WB-1:0]                best_w;
  logic                         looped_q;
  logic                         rd_valid_q;
  pnhs_pkg::scan_t              rd_kind_q;
  logic [NB-1:0]                rd_idx_q;

  logic                         ram_we;
  logic [AB-1:0]                ram_waddr;
  logic [WB-1:0]                ram_wdata;
  logic [AB-1:0]                ram_raddr;
  logic [WB-1:0]                ram_rdata;

  // clearing sweep has priority; a user write lands at the accept edge
  always_comb begin
    ram_we    = ctl.clear_we ||
                (ctl.capture && (pnhs_pkg::cmd_t'(command) == pnhs_pkg::CMD_WRITE));
    ram_waddr = ctl.clear_we ? ctl.clear_addr : {node[NB-1:0], target[NB-1:0], neighbour[NB-1:0]};
    ram_wdata = ctl.clear_we ? '0 : weight[WB-1:0];
    ram_raddr = {cur, target_q, ctl.scan_idx};
  end

  pnhs_ram #(
    .WIDTH(WB),
    .DEPTH(pnhs_pkg::DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign r_val   = prod[PB-1:RB];
  assign acc_new = acc + SB'(ram_rdata);

  assign stat.r_zero    = (r_val == '0);
  assign stat.at_target = (cur == target_q);
  assign stat.seen      = visited[cur];

  // read strobe is registered to line up with the ram's registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= ctl.scan_rd;
    end
    rd_kind_q <= ctl.scan_kind;
    rd_idx_q  <= ctl.scan_idx;
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q    <= pnhs_pkg::cmd_t'(command);
      cur      <= node[NB-1:0];
      target_q <= target[NB-1:0];
      frac_q   <= random_fraction[RB-1:0];
      count    <= '0;
      visited  <= '0;
      sum      <= '0;
      acc      <= '0;
      found    <= 1'b0;
      hop      <= '0;
      looped_q <= 1'b0;
    end else begin
      if (rd_valid_q) begin
        case (rd_kind_q)
          pnhs_pkg::SCAN_SUM: begin
            sum <= sum + SB'(ram_rdata);
          end
          pnhs_pkg::SCAN_SEL: begin
            acc <= acc_new;
            if (!found && (ram_rdata != '0) && (acc_new >= r_val)) begin
              found <= 1'b1;
              hop   <= rd_idx_q;
            end
          end
          pnhs_pkg::SCAN_BEST: begin
            // strict compare keeps the first maximum
            if (ram_rdata > best_w) begin
              best_w <= ram_rdata;
              best   <= rd_idx_q;
            end
          end
          default: begin
          end
        endcase
      end
      if (ctl.scale) begin
        prod <= PB'(sum) * PB'(frac_q);
      end
      if (ctl.best_init) begin
        best   <= '0;
        best_w <= '0;
      end
      if (ctl.mark) begin
        visited[cur] <= 1'b1;
      end
      if (ctl.set_loop) begin
        looped_q <= 1'b1;
      end
      if (ctl.advance) begin
        cur   <= best;
        count <= count + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      case (cmd_q)
        pnhs_pkg::CMD_DRAW: begin
          chosen_hop  <= stat.r_zero ? 4'd0 : 4'(hop);
          no_hop      <= stat.r_zero;
          path_length <= '0;
          looped      <= 1'b0;
        end
        pnhs_pkg::CMD_PATH: begin
          chosen_hop  <= '0;
          no_hop      <= 1'b0;
          path_length <= looped_q ? pnhs_pkg::LOOP_LENGTH : pnhs_pkg::LEN_BITS'(count);
          looped      <= looped_q;
        end
        default: begin
          chosen_hop  <= '0;
          no_hop      <= 1'b0;
          path_length <= '0;
          looped      <= 1'b0;
        end
      endcase
    end
  end

endmodule

[src/pnhs_ctrl.sv]
// controller: clearing sweep, command sequencing and result handshake
module pnhs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           command,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pnhs_pkg::dp_ctrl_t   ctl,
  input  pnhs_pkg::dp_stat_t   stat
);

  localparam int NB = pnhs_pkg::NODE_BITS;
  localparam int AB = pnhs_pkg::ADDR_BITS;
  localparam int CB = pnhs_pkg::SCAN_BITS;

  pnhs_pkg::state_t state, state_next;
  logic [AB-1:0]    clr_cnt, clr_cnt_next;
  logic [CB-1:0]    scan_cnt, scan_cnt_next;
  logic             out_valid_next;
  logic             scan_end;

  assign scan_end = scan_cnt[NB];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pnhs_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      scan_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      scan_cnt  <= scan_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    clr_cnt_next   = clr_cnt;
    scan_cnt_next  = '0;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;

    ctl            = '0;
    ctl.clear_addr = clr_cnt;
    ctl.scan_idx   = scan_cnt[NB-1:0];
    ctl.scan_kind  = pnhs_pkg::SCAN_SUM;

    case (state)
      pnhs_pkg::ST_CLEAR: begin
        ctl.clear_we = 1'b1;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == '1) begin
          state_next = pnhs_pkg::ST_IDLE;
        end
      end
      pnhs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          case (pnhs_pkg::cmd_t'(command))
            pnhs_pkg::CMD_DRAW: state_next = pnhs_pkg::ST_SUM;
            pnhs_pkg::CMD_PATH: state_next = pnhs_pkg::ST_PCHECK;
            default:            state_next = pnhs_pkg::ST_DONE;
          endcase
        end
      end
      pnhs_pkg::ST_SUM: begin
        ctl.scan_kind = pnhs_pkg::SCAN_SUM;
        ctl.scan_rd   = !scan_end;
        scan_cnt_next = scan_cnt + 1'b1;
        if (scan_end) begin
          state_next = pnhs_pkg::ST_SCALE;
        end
      end
      pnhs_pkg::ST_SCALE: begin
        ctl.scale  = 1'b1;
        state_next = pnhs_pkg::ST_CHECK;
      end
      pnhs_pkg::ST_CHECK: begin
        state_next = stat.r_zero ? pnhs_pkg::ST_DONE : pnhs_pkg::ST_SELECT;
      end
      pnhs_pkg::ST_SELECT: begin
        ctl.scan_kind = pnhs_pkg::SCAN_SEL;
        ctl.scan_rd   = !scan_end;
        scan_cnt_next = scan_cnt + 1'b1;
        if (scan_end) begin
          state_next = pnhs_pkg::ST_DONE;
        end
      end
      pnhs_pkg::ST_PCHECK: begin
        if (stat.at_target) begin
          state_next = pnhs_pkg::ST_DONE;
        end else if (stat.seen) begin
          ctl.set_loop = 1'b1;
          state_next   = pnhs_pkg::ST_DONE;
        end else begin
          ctl.mark      = 1'b1;
          ctl.best_init = 1'b1;
          state_next    = pnhs_pkg::ST_PSCAN;
        end
      end
      pnhs_pkg::ST_PSCAN: begin
        ctl.scan_kind = pnhs_pkg::SCAN_BEST;
        ctl.scan_rd   = !scan_end;
        scan_cnt_next = scan_cnt + 1'b1;
        if (scan_end) begin
          state_next = pnhs_pkg::ST_PADV;
        end
      end
      pnhs_pkg::ST_PADV: begin
        ctl.advance = 1'b1;
        state_next  = pnhs_pkg::ST_PCHECK;
      end
      pnhs_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          ctl.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = pnhs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pnhs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[src/pheromone_next_hop_selector_core.sv]
// top level of the pheromone next-hop selector
//
// usage
// - input channel (in_valid/in_ready) carries one command item: weight write,
//   roulette draw of a next hop, or greedy best-path length query
// - output channel (out_valid/out_ready) returns exactly one result item per
//   command; write and unused-code items return all-zero fields
// - weights live in a 4096 x 32 ram indexed by {node, target, neighbour}
// sequence from the accept edge to out_valid, one item at a time, paced by the
// single ram read port (each row scan reads the 16 entries of a row in turn)
// - write and unused code: ram written at the accept edge, then the result load
// - draw: a sum row scan, the 36x16 scaling multiply, a zero check, a select
//   row scan and the result load, in that order; the select scan is skipped
//   when the scaled value is zero
// - path: a check, a row scan and an advance per hop, at most 15 hops before a
//   repeat node ends the walk with a loop flag
// - in_ready returns in the same cycle that out_valid rises; items are taken
//   one at a time
// reset
// - after rst the ram is swept to zero, one entry per cycle, all 4096 entries,
//   while in_ready stays low
// stall
// - the result sits in an output register; the next item is accepted while
//   it waits, and the finished item is held back until out_ready frees it
module pheromone_next_hop_selector_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [3:0]  node,
  input  logic [3:0]  target,
  input  logic [3:0]  neighbour,
  input  logic [31:0] weight,
  input  logic [15:0] random_fraction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  chosen_hop,
  output logic        no_hop,
  output logic [9:0]  path_length,
  output logic        looped
);

  // command and status between sequencer and datapath
  pnhs_pkg::dp_ctrl_t ctl;
  pnhs_pkg::dp_stat_t stat;

  pnhs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ctl      (ctl),
    .stat     (stat)
  );

  // table, accumulators, multiplier and path walker
  pnhs_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .stat           (stat),
    .command        (command),
    .node           (node),
    .target         (target),
    .neighbour      (neighbour),
    .weight         (weight),
    .random_fraction(random_fraction),
    .chosen_hop     (chosen_hop),
    .no_hop         (no_hop),
    .path_length    (path_length),
    .looped         (looped)
  );

endmodule
